FILE: rtl/sdsch_pkg.sv
// shared types and constants of the scan disk scheduler
// no dependencies
`timescale 1ns / 1ps

package sdsch_pkg;

    localparam int CYL_W     = 16;
    localparam int MOVE_W    = 22;
    localparam int MAX_REQ   = 32;
    localparam int CNT_W     = $clog2(MAX_REQ + 1);
    localparam int IDX_W     = $clog2(MAX_REQ);
    localparam int Q_DEPTH   = 4;
    localparam int QPTR_W    = $clog2(Q_DEPTH);
    localparam int QCNT_W    = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_CYL    = 2'd2;

    localparam logic [CYL_W-1:0] START_HEAD_RST = 16'd0;
    localparam logic             SWEEP_UP_RST   = 1'b1;
    localparam logic [CYL_W-1:0] TOP_CYL_RST    = 16'd199;

    typedef struct packed {
        logic [CYL_W-1:0] cyl;
        logic             last;
    } t_req;

    typedef struct packed {
        logic [CYL_W-1:0] start_head;
        logic             sweep_up;
        logic [CYL_W-1:0] top_cyl;
    } t_cfg;

    typedef struct packed {
        logic [CYL_W-1:0]  cyl;
        logic [MOVE_W-1:0] move;
        logic              summary;
    } t_res;

endpackage

FILE: rtl/sdsch_front.sv
// front end: accepts request items into a short queue for the back end
// depends on sdsch_pkg
`timescale 1ns / 1ps

module sdsch_front
    import sdsch_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_q_valid,
    output t_req o_q_req,
    input  logic i_q_pop
);

    t_req              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;
    logic              push;
    logic              pop;

    assign o_stall   = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_req   = r_mem[r_rd];
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_req;
        end
    end

endmodule

FILE: rtl/sdsch_back.sv
// back end: sorted request row, split scan and scan-order service sequencer
// depends on sdsch_pkg
`timescale 1ns / 1ps

module sdsch_back
    import sdsch_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_q_valid,
    input  t_req i_q_req,
    output logic o_q_pop,
    output logic o_res_valid,
    output t_res o_res,
    input  logic i_res_stall
);

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_SPLIT  = 3'd1;
    localparam logic [2:0] S_UP     = 3'd2;
    localparam logic [2:0] S_DN     = 3'd3;
    localparam logic [2:0] S_TRAVEL = 3'd4;
    localparam logic [2:0] S_SUM    = 3'd5;

    logic [CYL_W-1:0]  r_store [MAX_REQ];
    logic [CYL_W-1:0]  ins_val [MAX_REQ];
    logic [MAX_REQ-1:0] gt;
    logic              ins_en;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_split, n_split;
    logic [CYL_W-1:0]  r_head, n_head;
    logic [MOVE_W-1:0] r_move, n_move;
    logic              r_phase, n_phase;
    logic              r_ovalid, n_ovalid;
    t_res              r_res, n_res;

    logic [CNT_W-1:0]  rd_ptr;
    logic [CYL_W-1:0]  rd_val;
    logic [CYL_W-1:0]  target;
    logic [CYL_W-1:0]  gap;
    logic [MOVE_W:0]   sum;
    logic [MOVE_W-1:0] new_move;
    logic              adv;

    // insert into the sorted row
    always_comb begin
        for (int i = 0; i < MAX_REQ; i++) begin
            gt[i] = (CNT_W'(i) < r_count) && (r_store[i] > i_q_req.cyl);
        end
        ins_val[0] = (gt[0] || r_count == '0) ? i_q_req.cyl : r_store[0];
        for (int i = 1; i < MAX_REQ; i++) begin
            if (gt[i-1]) begin
                ins_val[i] = r_store[i-1];
            end else if (gt[i] || CNT_W'(i) == r_count) begin
                ins_val[i] = i_q_req.cyl;
            end else begin
                ins_val[i] = r_store[i];
            end
        end
    end

    assign ins_en = (r_state == S_LOAD) && i_q_valid && (r_count < CNT_W'(MAX_REQ));

    always_ff @(posedge i_clk) begin
        if (ins_en) begin
            for (int i = 0; i < MAX_REQ; i++) begin
                r_store[i] <= ins_val[i];
            end
        end
    end

    // one read port, one move step
    assign rd_ptr   = (r_state == S_DN) ? r_ptr - CNT_W'(1) : r_ptr;
    assign rd_val   = r_store[rd_ptr[IDX_W-1:0]];
    assign target   = (r_state == S_TRAVEL) ? (i_cfg.sweep_up ? i_cfg.top_cyl : '0) : rd_val;
    assign gap      = (target > r_head) ? target - r_head : r_head - target;
    assign sum      = {1'b0, MOVE_W'(gap)} + {1'b0, r_move};
    assign new_move = sum[MOVE_W] ? '1 : sum[MOVE_W-1:0];
    assign adv      = !r_ovalid || !i_res_stall;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_split  = r_split;
        n_head   = r_head;
        n_move   = r_move;
        n_phase  = r_phase;
        n_ovalid = r_ovalid && i_res_stall;
        n_res    = r_res;
        o_q_pop  = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (r_count < CNT_W'(MAX_REQ)) begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_q_req.last) begin
                        n_ptr   = '0;
                        n_state = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                if (r_ptr < r_count && rd_val < i_cfg.start_head) begin
                    n_ptr = r_ptr + CNT_W'(1);
                end else begin
                    n_split = r_ptr;
                    n_head  = i_cfg.start_head;
                    n_move  = '0;
                    n_phase = 1'b0;
                    n_state = i_cfg.sweep_up ? S_UP : S_DN;
                end
            end
            S_UP, S_DN: begin
                if ((r_state == S_UP) ? (r_ptr < r_count) : (r_ptr != '0)) begin
                    if (adv) begin
                        n_head      = rd_val;
                        n_move      = new_move;
                        n_ovalid    = 1'b1;
                        n_res.cyl     = rd_val;
                        n_res.move    = new_move;
                        n_res.summary = 1'b0;
                        n_ptr = (r_state == S_UP) ? r_ptr + CNT_W'(1) : r_ptr - CNT_W'(1);
                    end
                end else begin
                    n_state = r_phase ? S_SUM : S_TRAVEL;
                end
            end
            S_TRAVEL: begin
                n_head  = target;
                n_move  = new_move;
                n_phase = 1'b1;
                n_ptr   = r_split;
                n_state = i_cfg.sweep_up ? S_DN : S_UP;
            end
            S_SUM: begin
                if (adv) begin
                    n_ovalid      = 1'b1;
                    n_res.cyl     = '0;
                    n_res.move    = r_move;
                    n_res.summary = 1'b1;
                    n_count       = '0;
                    n_state       = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_ptr    <= '0;
            r_split  <= '0;
            r_head   <= '0;
            r_move   <= '0;
            r_phase  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ptr    <= n_ptr;
            r_split  <= n_split;
            r_head   <= n_head;
            r_move   <= n_move;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;

endmodule

FILE: rtl/scan_disk_scheduler.sv
// top level of the scan (elevator) disk scheduler: config registers, front and back
// depends on sdsch_pkg, sdsch_front, sdsch_back
//
// channel   direction  handshake                 payload
// request   in         i_valid / o_stall         i_request_cylinder, i_last_request
// result    out        o_valid / i_stall         o_served_cylinder, o_movement_so_far,
//                                                o_is_summary, o_last_result
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// a request item is taken while the four-entry queue has room
// the summary of a batch of n stored requests follows its last item through the queue,
// a split scan up to the split (one entry per cycle), n serve steps on the single row
// read port, two sweep ends, one travel step and the summary
// reset is synchronous; no clearing pass, the row is read only where written
// a stalled result holds the sequencer; the queue keeps taking items meanwhile
`timescale 1ns / 1ps

module scan_disk_scheduler
    import sdsch_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [CYL_W-1:0]     i_request_cylinder,
    input  logic                 i_last_request,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [CYL_W-1:0]     o_served_cylinder,
    output logic [MOVE_W-1:0]    o_movement_so_far,
    output logic                 o_is_summary,
    output logic                 o_last_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CYL_W-1:0]     i_cfg_data
);

    t_cfg r_cfg;
    t_req in_req;
    t_req q_req;
    t_res res;
    logic q_valid;
    logic q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_head <= START_HEAD_RST;
            r_cfg.sweep_up   <= SWEEP_UP_RST;
            r_cfg.top_cyl    <= TOP_CYL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_START_HEAD: r_cfg.start_head <= i_cfg_data;
                CFG_SWEEP_UP:   r_cfg.sweep_up   <= i_cfg_data[0];
                CFG_TOP_CYL:    r_cfg.top_cyl    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign in_req.cyl  = i_request_cylinder;
    assign in_req.last = i_last_request;

    sdsch_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_req     (in_req),
        .o_q_valid (q_valid),
        .o_q_req   (q_req),
        .i_q_pop   (q_pop)
    );

    sdsch_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_req     (q_req),
        .o_q_pop     (q_pop),
        .o_res_valid (o_valid),
        .o_res       (res),
        .i_res_stall (i_stall)
    );

    assign o_served_cylinder = res.cyl;
    assign o_movement_so_far = res.move;
    assign o_is_summary      = res.summary;
    assign o_last_result     = res.summary;

endmodule

FILE: rtl/sdsch_checker.sv
// port-level checks on the result channel of the scan disk scheduler
// depends on sdsch_pkg; bound to scan_disk_scheduler
`timescale 1ns / 1ps

module sdsch_checker
    import sdsch_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [CYL_W-1:0]  o_served_cylinder,
    input logic [MOVE_W-1:0] o_movement_so_far,
    input logic              o_is_summary,
    input logic              o_last_result
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_served_cylinder)
            && $stable(o_movement_so_far) && $stable(o_is_summary))
        else $error("stalled result changed");

    a_summary_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_result |-> o_is_summary && o_served_cylinder == '0)
        else $error("malformed summary");

    a_move_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_is_summary |=>
            !o_valid || o_movement_so_far >= $past(o_movement_so_far))
        else $error("movement decreased within a batch");

endmodule

bind scan_disk_scheduler sdsch_checker u_sdsch_checker (.*);

FILE: sim/tb_top.sv
// self-checking testbench for the scan disk scheduler: directed batches, then random batches
// under three send/stall mixes; expected served order is computed in the bench itself
// depends on sdsch_pkg and scan_disk_scheduler
`timescale 1ns / 1ps

module tb_top;
    import sdsch_pkg::*;

    localparam int MOVE_MAX      = 4194303;
    localparam int SETTLE_CYCLES = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CYL_W-1:0]  cyl;
        logic [MOVE_W-1:0] move;
        logic              summary;
        logic              last;
    } t_served;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [CYL_W-1:0]     i_request_cylinder;
    logic                 i_last_request;
    logic                 o_valid;
    logic                 i_stall;
    logic [CYL_W-1:0]     o_served_cylinder;
    logic [MOVE_W-1:0]    o_movement_so_far;
    logic                 o_is_summary;
    logic                 o_last_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CYL_W-1:0]     i_cfg_data;

    // bench copy of the scheduler state
    logic [CYL_W-1:0]  cfg_start_head = START_HEAD_RST;
    logic              cfg_sweep_up   = SWEEP_UP_RST;
    logic [CYL_W-1:0]  cfg_top_cyl    = TOP_CYL_RST;
    logic [CYL_W-1:0]  batch_cyls[$];
    logic [CYL_W-1:0]  head_pos;
    logic [MOVE_W-1:0] total_move;
    t_served           served_due[$];

    int errors         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    scan_disk_scheduler uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_request_cylinder (i_request_cylinder),
        .i_last_request     (i_last_request),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_served_cylinder  (o_served_cylinder),
        .o_movement_so_far  (o_movement_so_far),
        .o_is_summary       (o_is_summary),
        .o_last_result      (o_last_result),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #6ms;
        $display("tb_top failed");
        $finish;
    end

    function automatic void move_head(input logic [CYL_W-1:0] target, input logic emit);
        int unsigned gap;
        int unsigned sum;
        t_served     r;
        gap = (target > head_pos) ? 32'(target) - 32'(head_pos)
                                  : 32'(head_pos) - 32'(target);
        sum = 32'(total_move) + gap;
        total_move = (sum > MOVE_MAX) ? MOVE_MAX[MOVE_W-1:0] : sum[MOVE_W-1:0];
        head_pos = target;
        if (emit) begin
            r.cyl     = target;
            r.move    = total_move;
            r.summary = 1'b0;
            r.last    = 1'b0;
            served_due.push_back(r);
        end
    endfunction

    // store one request; on the last one, work out the whole elevator order
    function automatic void plan_service(input logic [CYL_W-1:0] cyl, input logic last);
        logic [CYL_W-1:0] row[$];
        int               split;
        t_served          tail;
        if (batch_cyls.size() < MAX_REQ)
            batch_cyls.push_back(cyl);
        if (!last)
            return;
        row = batch_cyls;
        row.sort();
        split = 0;
        while (split < row.size() && row[split] < cfg_start_head)
            split++;
        head_pos   = cfg_start_head;
        total_move = '0;
        if (cfg_sweep_up) begin
            for (int i = split; i < row.size(); i++)
                move_head(row[i], 1'b1);
            move_head(cfg_top_cyl, 1'b0);
            for (int i = split - 1; i >= 0; i--)
                move_head(row[i], 1'b1);
        end else begin
            for (int i = split - 1; i >= 0; i--)
                move_head(row[i], 1'b1);
            move_head('0, 1'b0);
            for (int i = split; i < row.size(); i++)
                move_head(row[i], 1'b1);
        end
        tail.cyl     = '0;
        tail.move    = total_move;
        tail.summary = 1'b1;
        tail.last    = 1'b1;
        served_due.push_back(tail);
        batch_cyls.delete();
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_served want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (served_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result cyl %0d move %0d",
                                          o_served_cylinder, o_movement_so_far));
            end else begin
                want = served_due.pop_front();
                if (o_served_cylinder !== want.cyl)
                    report_mismatch($sformatf("served_cylinder %0d, want %0d",
                                              o_served_cylinder, want.cyl));
                if (o_movement_so_far !== want.move)
                    report_mismatch($sformatf("movement_so_far %0d, want %0d",
                                              o_movement_so_far, want.move));
                if (o_is_summary !== want.summary)
                    report_mismatch($sformatf("is_summary %0b, want %0b",
                                              o_is_summary, want.summary));
                if (o_last_result !== want.last)
                    report_mismatch($sformatf("last_result %0b, want %0b",
                                              o_last_result, want.last));
            end
        end
    end

    task automatic send_request(input logic [CYL_W-1:0] cyl, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid            <= 1'b1;
        i_request_cylinder <= cyl;
        i_last_request     <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        plan_service(cyl, last);
    endtask

    // hold requests back until every result is in and the block has settled
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (served_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CYL_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_START_HEAD: cfg_start_head = data;
            CFG_SWEEP_UP:   cfg_sweep_up   = data[0];
            CFG_TOP_CYL:    cfg_top_cyl    = data;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [CYL_W-1:0] head, input logic up,
                                input logic [CYL_W-1:0] top);
        logic [14:0] junk;
        junk = 15'($urandom);
        write_reg(CFG_START_HEAD, head);
        write_reg(CFG_SWEEP_UP, {junk, up});
        write_reg(CFG_TOP_CYL, top);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_request(16'd10, 1'b0);
        send_request(16'd65535, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd30, 1'b1);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        apply_config(16'd65535, 1'b0, 16'd1);
        send_request(16'd65535, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd32768, 1'b1);
        wait_idle();
        apply_config(16'd0, 1'b0, 16'd65535);
        send_request(16'd0, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd65535, 1'b1);
        wait_idle();
        apply_config(16'd65535, 1'b1, 16'd65535);
        send_request(16'd100, 1'b0);
        send_request(16'd65535, 1'b0);
        send_request(16'd200, 1'b1);
    endtask

    task automatic test_head_beyond_top();
        wait_idle();
        apply_config(16'd1000, 1'b1, 16'd1);
        send_request(16'd500, 1'b1);
        wait_idle();
        apply_config(16'd40000, 1'b1, 16'd20000);
        send_request(16'd45000, 1'b0);
        send_request(16'd10, 1'b1);
    endtask

    task automatic test_split_on_equal();
        wait_idle();
        apply_config(16'd300, 1'b0, 16'd199);
        write_reg(CFG_UNUSED, 16'($urandom));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        send_request(16'd300, 1'b0);
        send_request(16'd299, 1'b0);
        send_request(16'd301, 1'b0);
        send_request(16'd300, 1'b1);
    endtask

    function automatic logic [CYL_W-1:0] pick_cylinder();
        case ($urandom_range(3))
            0: return CYL_W'($urandom);
            1: return cfg_start_head + CYL_W'($urandom_range(40)) - CYL_W'(20);
            2: return CYL_W'($urandom_range(255));
            default: return CYL_W'($urandom_range(65535, 65280));
        endcase
    endfunction

    function automatic logic [CYL_W-1:0] pick_register(input logic [CYL_W-1:0] floor_val);
        case ($urandom_range(3))
            0: return floor_val;
            1: return 16'd65535;
            default: return (CYL_W'($urandom) < floor_val) ? floor_val : CYL_W'($urandom);
        endcase
    endfunction

    task automatic test_random_batches(input int send_pct, input int stall_pct,
                                       input int n_items);
        int sent;
        int len;
        int batches;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        sent    = 0;
        batches = 0;
        while (sent < n_items) begin
            if (batches % 4 == 0) begin
                wait_idle();
                apply_config(pick_register(16'd0), 1'($urandom), pick_register(16'd1));
            end
            // now and then overfill the store
            len = ($urandom_range(11) == 0) ? $urandom_range(36, 30) : $urandom_range(8, 1);
            for (int k = 0; k < len; k++)
                send_request(pick_cylinder(), k == len - 1);
            sent += len;
            batches++;
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_request_cylinder = '0;
        i_last_request     = 1'b0;
        i_stall            = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = CFG_START_HEAD;
        i_cfg_data         = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct  = 17;
        recv_stall_pct = 78;
        test_reset_defaults();
        test_register_extremes();
        test_head_beyond_top();
        test_split_on_equal();

        test_random_batches(17, 78, 67);
        test_random_batches(78, 17, 67);
        test_random_batches(0, 0, 67);

        wait_idle();
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
